/* rtl/kct_pkg.sv */
// Shared constants and types for the keyed client table.
`default_nettype none
package kct_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int KEY_W     = 32;
   localparam int ID_W      = 32;
   localparam int ENTRY_W   = KEY_W + ID_W;
   localparam int TYPE_W    = 2;
   localparam int IDX_W     = 4;
   localparam int POS_W     = 4;
   localparam int CNT_OUT_W = 5;

   localparam logic [TYPE_W-1:0] REQ_ADD  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_DEL  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_READ = 2'd2;

   typedef struct packed {
      logic                 added;
      logic                 full_res;
      logic                 del_found;
      logic [POS_W-1:0]     del_position;
      logic                 read_valid;
      logic [KEY_W-1:0]     read_key;
      logic [ID_W-1:0]      read_id;
      logic [CNT_OUT_W-1:0] entry_count;
   } rsp_type;

   // sequencer to response stage
   typedef struct packed {
      logic    done;
      rsp_type res;
   } seq_out_type;

endpackage
`default_nettype wire

/* rtl/kct_req_if.sv */
// Request channel: valid/ready plus request payload.
`default_nettype none
interface kct_req_if;
   logic                        valid;
   logic                        ready;
   logic [kct_pkg::TYPE_W-1:0]  req_type;
   logic [kct_pkg::KEY_W-1:0]   key;
   logic [kct_pkg::ID_W-1:0]    client_id;
   logic [kct_pkg::IDX_W-1:0]   index;

   modport source (output valid, req_type, key, client_id, index, input ready);
   modport sink   (input valid, req_type, key, client_id, index, output ready);
endinterface
`default_nettype wire

/* rtl/kct_rsp_if.sv */
// Response channel: valid/ready plus result payload.
`default_nettype none
interface kct_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          added;
   logic                          full_res;
   logic                          del_found;
   logic [kct_pkg::POS_W-1:0]     del_position;
   logic                          read_valid;
   logic [kct_pkg::KEY_W-1:0]     read_key;
   logic [kct_pkg::ID_W-1:0]      read_id;
   logic [kct_pkg::CNT_OUT_W-1:0] entry_count;

   modport source (output valid, added, full_res, del_found, del_position, read_valid,
                   read_key, read_id, entry_count, input ready);
   modport sink   (input valid, added, full_res, del_found, del_position, read_valid,
                   read_key, read_id, entry_count, output ready);
endinterface
`default_nettype wire

/* rtl/kct_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none
module kct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/kct_seq.sv */
// Request sequencer: key scan, append/update, delete compaction and indexed read.
`default_nettype none
module kct_seq #(
   parameter int CAPACITY = kct_pkg::CAPACITY_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   kct_req_if.sink                              req_chan,
   input  wire logic                            out_free,
   output      kct_pkg::seq_out_type            seq_out,
   output      logic                            ram_we,
   output      logic [$clog2(CAPACITY)-1:0]     ram_waddr,
   output      logic [kct_pkg::ENTRY_W-1:0]     ram_wdata,
   output      logic [$clog2(CAPACITY)-1:0]     ram_raddr,
   input  wire logic [kct_pkg::ENTRY_W-1:0]     ram_rdata
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CW > kct_pkg::IDX_W) ? CW : kct_pkg::IDX_W;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_SHIFT  = 5'b00100,
      S_RDWAIT = 5'b01000,
      S_DONE   = 5'b10000
   } seq_state_type;

   seq_state_type                 state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 scan_ff, scan_in;
   logic                          pend_ff, pend_in;
   logic [AW-1:0]                 pend_addr_ff, pend_addr_in;
   logic                          hit_ff, hit_in;
   logic [AW-1:0]                 hit_addr_ff, hit_addr_in;
   logic [CW-1:0]                 sh_ff, sh_in;
   logic                          shpend_ff, shpend_in;
   logic [AW-1:0]                 shpend_addr_ff, shpend_addr_in;
   logic [kct_pkg::TYPE_W-1:0]    op_ff, op_in;
   logic [kct_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [kct_pkg::ID_W-1:0]      id_ff, id_in;
   kct_pkg::rsp_type              res_ff, res_in;

   logic [IW-1:0]                 idx_ext;
   logic [IW-1:0]                 cnt_ext;
   logic                          rd_ok;
   logic                          scan_issue;
   logic                          key_match;
   logic [CW-1:0]                 sh_next;
   logic                          sh_issue;
   logic                          done;
   logic [kct_pkg::KEY_W-1:0]     rd_key;

   assign idx_ext    = IW'(req_chan.index);
   assign cnt_ext    = IW'(count_ff);
   assign rd_ok      = idx_ext < cnt_ext;
   assign scan_issue = scan_ff < count_ff;
   assign rd_key     = ram_rdata[kct_pkg::ENTRY_W-1:kct_pkg::ID_W];
   assign key_match  = pend_ff && (rd_key == key_ff);
   assign sh_next    = CW'(sh_ff + 1'b1);
   assign sh_issue   = sh_next < count_ff;

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      pend_in        = 1'b0;
      pend_addr_in   = scan_ff[AW-1:0];
      hit_in         = hit_ff;
      hit_addr_in    = hit_addr_ff;
      sh_in          = sh_ff;
      shpend_in      = 1'b0;
      shpend_addr_in = sh_ff[AW-1:0];
      op_in          = op_ff;
      key_in         = key_ff;
      id_in          = id_ff;
      res_in         = res_ff;
      ram_we         = 1'b0;
      ram_waddr      = pend_addr_ff;
      ram_wdata      = {key_ff, id_ff};
      ram_raddr      = scan_ff[AW-1:0];
      done           = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            ram_raddr = AW'(idx_ext);
            if (req_chan.valid) begin
               op_in   = req_chan.req_type;
               key_in  = req_chan.key;
               id_in   = req_chan.client_id;
               res_in  = '0;
               scan_in = '0;
               hit_in  = 1'b0;
               priority if (req_chan.req_type == kct_pkg::REQ_ADD ||
                            req_chan.req_type == kct_pkg::REQ_DEL) begin
                  state_in = S_SCAN;
               end else if (req_chan.req_type == kct_pkg::REQ_READ && rd_ok) begin
                  state_in = S_RDWAIT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_SCAN: begin
            // one read issued per cycle, compare lands in the cycle after
            pend_in = scan_issue;
            if (scan_issue) begin
               scan_in = CW'(scan_ff + 1'b1);
            end
            if (op_ff == kct_pkg::REQ_ADD) begin
               if (key_match) begin
                  ram_we    = 1'b1;
                  ram_waddr = pend_addr_ff;
                  state_in  = S_DONE;
               end else if (!scan_issue && !pend_ff) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     res_in.full_res = 1'b1;
                  end else begin
                     ram_we         = 1'b1;
                     ram_waddr      = count_ff[AW-1:0];
                     count_in       = CW'(count_ff + 1'b1);
                     res_in.added   = 1'b1;
                  end
                  state_in = S_DONE;
               end
            end else begin
               // delete keeps the last match
               if (key_match) begin
                  hit_in      = 1'b1;
                  hit_addr_in = pend_addr_ff;
               end
               if (!scan_issue && !pend_ff) begin
                  if (hit_ff) begin
                     sh_in    = CW'(hit_addr_ff);
                     state_in = S_SHIFT;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end

         S_SHIFT: begin
            // read entry above, write it one place down next cycle
            ram_raddr = sh_next[AW-1:0];
            shpend_in = sh_issue;
            if (sh_issue) begin
               sh_in = sh_next;
            end
            if (shpend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = shpend_addr_ff;
               ram_wdata = ram_rdata;
            end
            if (!sh_issue && !shpend_ff) begin
               count_in            = CW'(count_ff - 1'b1);
               res_in.del_found    = 1'b1;
               res_in.del_position = kct_pkg::POS_W'(hit_addr_ff);
               state_in            = S_DONE;
            end
         end

         S_RDWAIT: begin
            res_in.read_valid = 1'b1;
            res_in.read_key   = rd_key;
            res_in.read_id    = ram_rdata[kct_pkg::ID_W-1:0];
            state_in          = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         scan_ff   <= '0;
         pend_ff   <= 1'b0;
         hit_ff    <= 1'b0;
         sh_ff     <= '0;
         shpend_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         scan_ff   <= scan_in;
         pend_ff   <= pend_in;
         hit_ff    <= hit_in;
         sh_ff     <= sh_in;
         shpend_ff <= shpend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff   <= pend_addr_in;
      hit_addr_ff    <= hit_addr_in;
      shpend_addr_ff <= shpend_addr_in;
      op_ff          <= op_in;
      key_ff         <= key_in;
      id_ff          <= id_in;
      res_ff         <= res_in;
   end

   always_comb begin
      seq_out                 = '0;
      seq_out.done            = done;
      seq_out.res             = res_ff;
      seq_out.res.entry_count = kct_pkg::CNT_OUT_W'(count_ff);
   end
endmodule
`default_nettype wire

/* rtl/keyed_client_table.sv */
// Top level of the keyed client table: sequencer, entry RAM and response register.
`default_nettype none
// Ordered table of up to CAPACITY {key, client id} entries held in one RAM
// (64-bit words, one write and one registered read port). Requests are taken
// one at a time. A delete scans every entry and an add scans until it meets
// its key, at one read per cycle, and then hands the result over to the output
// register; a delete that hits first compacts the entries above the removed
// one at one per cycle. A read does one RAM read before the hand-over, or none
// when the index is out of range or the type is unknown. The hand-over waits
// while the output register is full; the single RAM read port sets the pace.
// A new request is taken while the previous response still waits in the
// output register. No clearing pass after reset: only entries below the count
// are ever read.
module keyed_client_table #(
   parameter int CAPACITY = kct_pkg::CAPACITY_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   kct_req_if.sink   req_chan,
   kct_rsp_if.source rsp_chan
);
   localparam int AW = $clog2(CAPACITY);

   kct_pkg::seq_out_type        seq_out;
   logic                        out_free;
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [kct_pkg::ENTRY_W-1:0] ram_wdata;
   logic [AW-1:0]               ram_raddr;
   logic [kct_pkg::ENTRY_W-1:0] ram_rdata;

   logic                        rsp_valid_ff, rsp_valid_in;
   kct_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   kct_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_free  (out_free),
      .seq_out   (seq_out),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   kct_ram #(
      .WIDTH (kct_pkg::ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // output slot frees when empty or its beat is taken this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (seq_out.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_out.res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.added        = rsp_data_ff.added;
   assign rsp_chan.full_res     = rsp_data_ff.full_res;
   assign rsp_chan.del_found    = rsp_data_ff.del_found;
   assign rsp_chan.del_position = rsp_data_ff.del_position;
   assign rsp_chan.read_valid   = rsp_data_ff.read_valid;
   assign rsp_chan.read_key     = rsp_data_ff.read_key;
   assign rsp_chan.read_id      = rsp_data_ff.read_id;
   assign rsp_chan.entry_count  = rsp_data_ff.entry_count;
endmodule
`default_nettype wire
